// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PTRA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptra_pkg.sv =====
`timescale 1ns / 1ps

package ptra_pkg;

  typedef enum logic [1:0] {
    CMD_REPORT  = 2'd0,
    CMD_CLEANUP = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_CLEANED   = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_READ_MISS = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RD_ISSUE,
    S_RD_DATA
  } state_t;

  localparam logic [23:0] AGE_LIMIT_RESET = 24'd327680;

endpackage

// ===== rtl/peer_table_rssi_replace_aging_core.sv =====
`timescale 1ns / 1ps
// Peer table with signal-strength replacement and aging.
// Command channel: a word is taken at a rising edge with start high and busy
// low. in_cmd selects report, cleanup or read; an unused code is taken and
// ignored. Results come back as one word on the out_ ports, marked by a
// single-cycle out_valid; the receiver cannot stall, so there is no hold.
// Report and cleanup walk the table through one memory read port, one entry
// a cycle, pipelined one deep; a report ends the walk early on a hit. Read
// goes through the registered memory read (S_RD_ISSUE, then S_RD_DATA); an
// out-of-range read answers straight from idle. busy is high while a walk or
// read runs.
// cfg_we/cfg_wdata load the age limit at any edge; write it only when idle.
// Reset (rst_n low, synchronous) empties the table and restores the age
// limit; entry storage is not cleared, and only written entries are read.
`include "assert_macros.svh"

module peer_table_rssi_replace_aging_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [47:0]        in_peer_mac,
  input  logic signed [7:0]  in_signal_dbm,
  input  logic [2:0]         in_peer_kind,
  input  logic               in_kind_known,
  input  logic [23:0]        in_time_now,
  input  logic [3:0]         in_read_slot,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [3:0]         out_slot,
  output logic [4:0]         out_entry_count,
  output logic [4:0]         out_removed_count,
  output logic [47:0]        out_entry_mac,
  output logic signed [7:0]  out_entry_signal,
  output logic [2:0]         out_entry_kind
);
  import ptra_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [23:0]          age_limit_r;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic [AW-1:0]        ev_idx_r, ev_idx_nxt;
  logic [CW-1:0]        w_r, w_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic                 min_vld_r, min_vld_nxt;
  logic signed [7:0]    min_sig_r, min_sig_nxt;
  logic [AW-1:0]        min_idx_r, min_idx_nxt;

  logic [1:0]           cmd_r;
  logic [47:0]          mac_r;
  logic signed [7:0]    sig_r;
  logic [2:0]           kind_r;
  logic                 known_r;
  logic [TIME_BITS-1:0] now_r;
  logic [3:0]           rslot_r;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [3:0]           out_slot_r, out_slot_nxt;
  logic [4:0]           out_count_r, out_count_nxt;
  logic [4:0]           out_removed_r, out_removed_nxt;
  logic [47:0]          out_mac_r, out_mac_nxt;
  logic signed [7:0]    out_sig_r, out_sig_nxt;
  logic [2:0]           out_kind_r, out_kind_nxt;

  logic [47:0]          mac_mem  [TABLE_DEPTH];
  logic signed [7:0]    sig_mem  [TABLE_DEPTH];
  logic [2:0]           kind_mem [TABLE_DEPTH];
  logic [TIME_BITS-1:0] time_mem [TABLE_DEPTH];

  logic [AW-1:0]        rd_addr;
  logic [47:0]          rd_mac;
  logic signed [7:0]    rd_sig;
  logic [2:0]           rd_kind;
  logic [TIME_BITS-1:0] rd_time;

  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [47:0]          wd_mac;
  logic signed [7:0]    wd_sig;
  logic [2:0]           wd_kind;
  logic [TIME_BITS-1:0] wd_time;

  logic                 accept;
  logic [55:0]          time_ext;
  logic [TIME_BITS-1:0] now_in;
  logic [TIME_BITS-1:0] age;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign time_ext = {32'd0, in_time_now};
  assign now_in   = time_ext[TIME_BITS-1:0];
  assign rd_addr  = rd_idx_r[AW-1:0];
  assign age      = now_r - rd_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    rd_idx_nxt      = rd_idx_r;
    ev_vld_nxt      = ev_vld_r;
    ev_idx_nxt      = ev_idx_r;
    w_nxt           = w_r;
    rem_nxt         = rem_r;
    min_vld_nxt     = min_vld_r;
    min_sig_nxt     = min_sig_r;
    min_idx_nxt     = min_idx_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_count_nxt   = out_count_r;
    out_removed_nxt = out_removed_r;
    out_mac_nxt     = out_mac_r;
    out_sig_nxt     = out_sig_r;
    out_kind_nxt    = out_kind_r;
    mem_we          = 1'b0;
    mem_wa          = ev_idx_r;
    wd_mac          = mac_r;
    wd_sig          = sig_r;
    wd_kind         = kind_r;
    wd_time         = now_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_REPORT, CMD_CLEANUP: begin
              state_nxt   = S_SCAN;
              rd_idx_nxt  = '0;
              ev_vld_nxt  = 1'b0;
              w_nxt       = '0;
              rem_nxt     = '0;
              min_vld_nxt = 1'b0;
            end
            CMD_READ: begin
              if (32'(in_read_slot) < 32'(fill_r)) begin
                state_nxt  = S_RD_ISSUE;
                rd_idx_nxt = CW'(in_read_slot);
              end else begin
                out_valid_nxt   = 1'b1;
                out_status_nxt  = ST_READ_MISS;
                out_slot_nxt    = in_read_slot;
                out_count_nxt   = 5'(fill_r);
                out_removed_nxt = '0;
                out_mac_nxt     = '0;
                out_sig_nxt     = '0;
                out_kind_nxt    = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (rd_idx_r < fill_r) begin
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          ev_vld_nxt = 1'b0;
        end

        out_removed_nxt = '0;
        out_mac_nxt     = '0;
        out_sig_nxt     = '0;
        out_kind_nxt    = '0;

        if (ev_vld_r) begin
          if (cmd_r == CMD_REPORT) begin
            if (rd_mac == mac_r) begin
              mem_we         = 1'b1;
              mem_wa         = ev_idx_r;
              wd_kind        = known_r ? kind_r : rd_kind;
              ev_vld_nxt     = 1'b0;
              state_nxt      = S_IDLE;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_UPDATED;
              out_slot_nxt   = 4'(ev_idx_r);
              out_count_nxt  = 5'(fill_r);
            end else if (!min_vld_r || rd_sig < min_sig_r) begin
              min_vld_nxt = 1'b1;
              min_sig_nxt = rd_sig;
              min_idx_nxt = ev_idx_r;
            end
          end else begin
            if (32'(age) > 32'(age_limit_r)) begin
              rem_nxt = rem_r + 1'b1;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = w_r[AW-1:0];
              wd_mac  = rd_mac;
              wd_sig  = rd_sig;
              wd_kind = rd_kind;
              wd_time = rd_time;
              w_nxt   = w_r + 1'b1;
            end
          end
        end else if (rd_idx_r >= fill_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_REPORT) begin
            if (32'(fill_r) < TABLE_DEPTH) begin
              mem_we         = 1'b1;
              mem_wa         = fill_r[AW-1:0];
              fill_nxt       = fill_r + 1'b1;
              out_status_nxt = ST_INSERTED;
              out_slot_nxt   = 4'(fill_r);
              out_count_nxt  = 5'(fill_r + 1'b1);
            end else if (sig_r > min_sig_r) begin
              mem_we         = 1'b1;
              mem_wa         = min_idx_r;
              out_status_nxt = ST_REPLACED;
              out_slot_nxt   = 4'(min_idx_r);
              out_count_nxt  = 5'(fill_r);
            end else begin
              out_status_nxt = ST_DROPPED;
              out_slot_nxt   = '0;
              out_count_nxt  = 5'(fill_r);
            end
          end else begin
            fill_nxt        = w_r;
            out_status_nxt  = ST_CLEANED;
            out_slot_nxt    = '0;
            out_count_nxt   = 5'(w_r);
            out_removed_nxt = 5'(rem_r);
          end
        end
      end

      S_RD_ISSUE: begin
        state_nxt = S_RD_DATA;
      end

      S_RD_DATA: begin
        state_nxt       = S_IDLE;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_READ_OK;
        out_slot_nxt    = rslot_r;
        out_count_nxt   = 5'(fill_r);
        out_removed_nxt = '0;
        out_mac_nxt     = rd_mac;
        out_sig_nxt     = rd_sig;
        out_kind_nxt    = rd_kind;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= AGE_LIMIT_RESET;
      fill_r      <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
      w_r         <= '0;
      rem_r       <= '0;
      min_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        age_limit_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      w_r         <= w_nxt;
      rem_r       <= rem_nxt;
      min_vld_r   <= min_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r      <= ev_idx_nxt;
    min_sig_r     <= min_sig_nxt;
    min_idx_r     <= min_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_count_r   <= out_count_nxt;
    out_removed_r <= out_removed_nxt;
    out_mac_r     <= out_mac_nxt;
    out_sig_r     <= out_sig_nxt;
    out_kind_r    <= out_kind_nxt;
    if (accept) begin
      cmd_r   <= in_cmd;
      mac_r   <= in_peer_mac;
      sig_r   <= in_signal_dbm;
      kind_r  <= in_peer_kind;
      known_r <= in_kind_known;
      now_r   <= now_in;
      rslot_r <= in_read_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mac_mem[mem_wa]  <= wd_mac;
      sig_mem[mem_wa]  <= wd_sig;
      kind_mem[mem_wa] <= wd_kind;
      time_mem[mem_wa] <= wd_time;
    end
    rd_mac  <= mac_mem[rd_addr];
    rd_sig  <= sig_mem[rd_addr];
    rd_kind <= kind_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_entry_count   = out_count_r;
  assign out_removed_count = out_removed_r;
  assign out_entry_mac     = out_mac_r;
  assign out_entry_signal  = out_sig_r;
  assign out_entry_kind    = out_kind_r;

  `PTRA_ASSERT_NEXT(a_walk_busy, accept && (in_cmd == CMD_REPORT || in_cmd == CMD_CLEANUP), busy, "walk did not start")
  `PTRA_ASSERT(a_strobe_idle, out_valid_r, state_r == S_IDLE, "result shown while busy")
  `PTRA_ASSERT(a_removed_only_cleanup, out_valid_r && out_status_r != ST_CLEANED, out_removed_r == '0, "removed count outside cleanup")
  `PTRA_ASSERT(a_eval_in_scan, ev_vld_r, state_r == S_SCAN, "read data pending outside walk")

endmodule

// ===== sim/peer_table_checker.sv =====
`timescale 1ns / 1ps

module peer_table_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic [47:0]       in_peer_mac,
  input  logic signed [7:0] in_signal_dbm,
  input  logic [2:0]        in_peer_kind,
  input  logic              in_kind_known,
  input  logic [23:0]       in_time_now,
  input  logic [3:0]        in_read_slot,
  input  logic              cfg_we,
  input  logic [23:0]       cfg_wdata,
  input  logic              out_valid,
  input  logic [2:0]        out_status,
  input  logic [3:0]        out_slot,
  input  logic [4:0]        out_entry_count,
  input  logic [4:0]        out_removed_count,
  input  logic [47:0]       out_entry_mac,
  input  logic signed [7:0] out_entry_signal,
  input  logic [2:0]        out_entry_kind,
  output int                mismatch_count,
  output int                pending_count
);
  import ptra_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    status_t            status;
    logic [3:0]         slot;
    logic [4:0]         count;
    logic [4:0]         removed;
    logic [47:0]        mac;
    logic signed [7:0]  sig;
    logic [2:0]         kind;
  } table_reply_t;

  logic [47:0]       mac_tab  [DEPTH];
  logic signed [7:0] sig_tab  [DEPTH];
  logic [2:0]        kind_tab [DEPTH];
  logic [23:0]       seen_tab [DEPTH];
  int                fill;
  logic [23:0]       age_limit;
  table_reply_t      reply_q [$];

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  task automatic apply_to_table();
    table_reply_t r;
    int hit;
    int weakest;
    int w;
    logic [23:0] age;
    r.status  = ST_UPDATED;
    r.slot    = '0;
    r.removed = '0;
    r.mac     = '0;
    r.sig     = '0;
    r.kind    = '0;
    case (in_cmd)
      CMD_REPORT: begin
        hit = -1;
        for (int i = 0; i < fill; i++)
          if (hit < 0 && mac_tab[i] == in_peer_mac) hit = i;
        if (hit >= 0) begin
          sig_tab[hit]  = in_signal_dbm;
          seen_tab[hit] = in_time_now;
          if (in_kind_known) kind_tab[hit] = in_peer_kind;
          r.status = ST_UPDATED;
          r.slot   = 4'(hit);
        end else if (fill < DEPTH) begin
          mac_tab[fill]  = in_peer_mac;
          sig_tab[fill]  = in_signal_dbm;
          kind_tab[fill] = in_peer_kind;
          seen_tab[fill] = in_time_now;
          r.status = ST_INSERTED;
          r.slot   = 4'(fill);
          fill++;
        end else begin
          weakest = 0;
          for (int i = 1; i < DEPTH; i++)
            if (sig_tab[i] < sig_tab[weakest]) weakest = i;
          if (in_signal_dbm > sig_tab[weakest]) begin
            mac_tab[weakest]  = in_peer_mac;
            sig_tab[weakest]  = in_signal_dbm;
            kind_tab[weakest] = in_peer_kind;
            seen_tab[weakest] = in_time_now;
            r.status = ST_REPLACED;
            r.slot   = 4'(weakest);
          end else begin
            r.status = ST_DROPPED;
          end
        end
      end
      CMD_CLEANUP: begin
        w = 0;
        for (int i = 0; i < fill; i++) begin
          age = in_time_now - seen_tab[i];
          if (age > age_limit) begin
            r.removed++;
          end else begin
            mac_tab[w]  = mac_tab[i];
            sig_tab[w]  = sig_tab[i];
            kind_tab[w] = kind_tab[i];
            seen_tab[w] = seen_tab[i];
            w++;
          end
        end
        fill = w;
        r.status = ST_CLEANED;
      end
      CMD_READ: begin
        r.slot = in_read_slot;
        if (int'(in_read_slot) < fill) begin
          r.status = ST_READ_OK;
          r.mac    = mac_tab[in_read_slot];
          r.sig    = sig_tab[in_read_slot];
          r.kind   = kind_tab[in_read_slot];
        end else begin
          r.status = ST_READ_MISS;
        end
      end
      default: return;
    endcase
    r.count = 5'(fill);
    reply_q.push_back(r);
  endtask

  task automatic compare_word();
    table_reply_t e;
    if (reply_q.size() == 0) begin
      report_mismatch("word with nothing pending, status", -1, out_status);
      return;
    end
    e = reply_q.pop_front();
    if (out_status !== e.status) report_mismatch("status", e.status, out_status);
    if (out_slot !== e.slot) report_mismatch("slot", e.slot, out_slot);
    if (out_entry_count !== e.count) report_mismatch("entry_count", e.count, out_entry_count);
    if (out_removed_count !== e.removed)
      report_mismatch("removed_count", e.removed, out_removed_count);
    if (out_entry_mac !== e.mac) report_mismatch("entry_mac", e.mac, out_entry_mac);
    if (out_entry_signal !== e.sig) report_mismatch("entry_signal", e.sig, out_entry_signal);
    if (out_entry_kind !== e.kind) report_mismatch("entry_kind", e.kind, out_entry_kind);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      age_limit = AGE_LIMIT_RESET;
      reply_q.delete();
    end else begin
      if (out_valid) compare_word();
      if (cfg_we) age_limit = cfg_wdata;
      if (start && !busy) apply_to_table();
    end
    pending_count <= reply_q.size();
  end

endmodule

// ===== sim/peer_table_rssi_replace_aging_core_tb.sv =====
`timescale 1ns / 1ps

module peer_table_rssi_replace_aging_core_tb;
  import ptra_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES    = 30;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 140;
  localparam int POOL_SIZE       = 40;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              start         = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd        = CMD_REPORT;
  logic [47:0]       in_peer_mac   = '0;
  logic signed [7:0] in_signal_dbm = '0;
  logic [2:0]        in_peer_kind  = '0;
  logic              in_kind_known = 1'b0;
  logic [23:0]       in_time_now   = '0;
  logic [3:0]        in_read_slot  = '0;
  logic              cfg_we        = 1'b0;
  logic [23:0]       cfg_wdata     = '0;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [3:0]        out_slot;
  logic [4:0]        out_entry_count;
  logic [4:0]        out_removed_count;
  logic [47:0]       out_entry_mac;
  logic signed [7:0] out_entry_signal;
  logic [2:0]        out_entry_kind;

  int          mismatch_count;
  int          pending_count;
  int          cycles = 0;
  bit          gaps_on = 1'b1;
  logic [47:0] mac_pool [POOL_SIZE];
  logic [23:0] tick = '0;

  peer_table_rssi_replace_aging_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_peer_mac       (in_peer_mac),
    .in_signal_dbm     (in_signal_dbm),
    .in_peer_kind      (in_peer_kind),
    .in_kind_known     (in_kind_known),
    .in_time_now       (in_time_now),
    .in_read_slot      (in_read_slot),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_entry_count   (out_entry_count),
    .out_removed_count (out_removed_count),
    .out_entry_mac     (out_entry_mac),
    .out_entry_signal  (out_entry_signal),
    .out_entry_kind    (out_entry_kind)
  );

  peer_table_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_peer_mac       (in_peer_mac),
    .in_signal_dbm     (in_signal_dbm),
    .in_peer_kind      (in_peer_kind),
    .in_kind_known     (in_kind_known),
    .in_time_now       (in_time_now),
    .in_read_slot      (in_read_slot),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_entry_count   (out_entry_count),
    .out_removed_count (out_removed_count),
    .out_entry_mac     (out_entry_mac),
    .out_entry_signal  (out_entry_signal),
    .out_entry_kind    (out_entry_kind),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [47:0] mac,
                           input logic signed [7:0] sig, input logic [2:0] kind,
                           input logic known, input logic [23:0] tnow,
                           input logic [3:0] rslot);
    int g;
    in_cmd        <= cmd;
    in_peer_mac   <= mac;
    in_signal_dbm <= sig;
    in_peer_kind  <= kind;
    in_kind_known <= known;
    in_time_now   <= tnow;
    in_read_slot  <= rslot;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait for every pending word, then cover a trailing cmd that yields none
  task automatic drain_table_ops();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_age_limit(input logic [23:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    int pool_n;
    int step_max;
    int pick;
    logic [23:0] limit;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = 48'({$urandom, $urandom});
    mac_pool[0] = '0;
    mac_pool[1] = '1;

    // empty-table reads, extremes, hit with and without kind, time wrap
    send_word(CMD_READ, '0, '0, '0, 1'b0, '0, 4'd0);
    send_word(CMD_READ, '1, '1, '1, 1'b1, '1, 4'd15);
    send_word(CMD_REPORT, 48'h0, 8'h80, 3'd0, 1'b0, 24'hFFFFF0, 4'd0);
    send_word(CMD_REPORT, '1, 8'sd127, 3'd7, 1'b1, 24'hFFFFF8, 4'd0);
    send_word(CMD_REPORT, 48'h0, 8'sd5, 3'd7, 1'b0, 24'hFFFFFC, 4'd0);
    send_word(CMD_REPORT, '1, -8'sd1, 3'd2, 1'b1, 24'h000000, 4'd0);
    send_word(CMD_READ, '0, '0, '0, 1'b0, '0, 4'd0);
    send_word(CMD_READ, '0, '0, '0, 1'b0, '0, 4'd1);
    send_word(CMD_READ, '0, '0, '0, 1'b0, '0, 4'd2);
    send_word(CMD_UNUSED, '1, '1, '1, 1'b1, '1, 4'd15);
    send_word(CMD_CLEANUP, '0, '0, '0, 1'b0, 24'h000010, 4'd0);
    for (int i = 0; i < 14; i++)
      send_word(CMD_REPORT, 48'h00005EED0000 + 48'(i), 8'(i - 20), 3'(i), 1'b0,
                24'(32 + i), 4'd0);
    // full table: equal signal is dropped, stronger replaces the weakest
    send_word(CMD_REPORT, 48'hA5A5A5A5A5A5, -8'sd20, 3'd1, 1'b1, 24'h000030, 4'd0);
    send_word(CMD_REPORT, 48'h5A5A5A5A5A5A, 8'sd127, 3'd6, 1'b1, 24'h000030, 4'd0);
    send_word(CMD_READ, '0, '0, '0, 1'b0, '0, 4'd15);
    drain_table_ops();
    write_age_limit(24'd0);
    send_word(CMD_CLEANUP, '0, '0, '0, 1'b0, 24'h000040, 4'd0);

    for (int p = 0; p < PHASES; p++) begin
      drain_table_ops();
      case (p % 6)
        0: limit = 24'd0;
        1: limit = 24'hFFFFFF;
        2: limit = AGE_LIMIT_RESET;
        3: limit = 24'($urandom_range(1, 4000));
        4: limit = 24'($urandom);
        default: limit = 24'($urandom_range(1, 64));
      endcase
      write_age_limit(limit);
      gaps_on = (p % 4 != 3);
      pool_n = $urandom_range(10, POOL_SIZE);
      step_max = int'(limit >> 2) + 2;
      n = 0;
      while (n < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 64) begin
          tick = tick + 24'($urandom_range(0, step_max));
          send_word(CMD_REPORT,
                    ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom})
                                                : mac_pool[$urandom_range(0, pool_n - 1)],
                    8'($urandom), 3'($urandom), 1'($urandom),
                    ($urandom_range(0, 29) == 0) ? 24'($urandom) : tick,
                    4'($urandom));
          n++;
        end else if (pick < 74) begin
          send_word(CMD_CLEANUP, 48'({$urandom, $urandom}), 8'($urandom), 3'($urandom),
                    1'($urandom), 24'(tick + 24'($urandom_range(0, step_max))),
                    4'($urandom));
          n++;
        end else if (pick < 95) begin
          send_word(CMD_READ, 48'({$urandom, $urandom}), 8'($urandom), 3'($urandom),
                    1'($urandom), 24'($urandom), 4'($urandom));
          n++;
        end else begin
          send_word(CMD_UNUSED, 48'({$urandom, $urandom}), 8'($urandom), 3'($urandom),
                    1'($urandom), 24'($urandom), 4'($urandom));
        end
        if ($urandom_range(0, 199) == 0) drain_table_ops();
      end
    end

    drain_table_ops();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
